/* rtl/core/path_speed_accel_profiler_defines.svh */
// Assertion macros shared by the profiler RTL.
// Expects clk and arst_n in the scope of each use; empty when SYNTH is defined.
`ifndef PATH_SPEED_ACCEL_PROFILER_DEFINES_SVH
`define PATH_SPEED_ACCEL_PROFILER_DEFINES_SVH

`ifndef SYNTH

`define PSAP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psap: same-cycle check failed");

`define PSAP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psap: next-cycle check failed");

`else

`define PSAP_ASSERT_IMP(label, ante, cons)

`define PSAP_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/core/psap_pkg.sv */
// Package for the path speed and acceleration profiler.
// Holds payload structs, register indexes, the quarter-wave sine table and helpers.
package psap_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_STEP = 1'd1;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
		logic [15:0] heading;
		logic run_end;
	} point_t;

	typedef struct packed {
		logic signed [31:0] velocity;
		logic signed [31:0] acceleration;
		logic [47:0] elapsed_time;
		logic status;
		logic last_of_run;
	} result_t;

	typedef struct packed {
		logic [4:0] idx;
		logic [9:0] frac;
		logic neg;
	} sine_sel_t;

	localparam logic [16:0] SINE_BASE [17] = '{
		17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893, 17'd36410,
		17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547,
		17'd62714, 17'd64277, 17'd65220, 17'd65536
	};

	localparam logic [12:0] SINE_STEP [17] = '{
		13'd6424, 13'd6361, 13'd6239, 13'd6056, 13'd5813, 13'd5517, 13'd5166,
		13'd4765, 13'd4319, 13'd3831, 13'd3307, 13'd2749, 13'd2167, 13'd1563,
		13'd943, 13'd316, 13'd0
	};

	function automatic sine_sel_t sine_select(input logic [15:0] angle);
		sine_sel_t sel;
		logic [14:0] r;
		if (angle[14]) begin
			r = 15'd16384 - {1'b0, angle[13:0]};
		end else begin
			r = {1'b0, angle[13:0]};
		end
		sel.idx = r[14:10];
		sel.frac = r[9:0];
		sel.neg = angle[15];
		return sel;
	endfunction

	function automatic logic signed [17:0] sine_finish(input sine_sel_t sel,
			input logic [22:0] step_prod);
		logic [22:0] rounded;
		logic [16:0] mag;
		rounded = step_prod + 23'd512;
		mag = SINE_BASE[sel.idx] + {4'd0, rounded[22:10]};
		if (sel.neg) begin
			return -$signed({1'b0, mag});
		end
		return $signed({1'b0, mag});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -42'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

/* rtl/core/path_speed_accel_profiler.sv */
// Path speed and acceleration profiler: central-difference speed along heading and
// forward-difference acceleration over a run of path points. Depends on psap_pkg and
// the assertion macros in path_speed_accel_profiler_defines.svh.
//
// The first two points of a run are taken in idle without the multiplier. Every later
// point steps one shared 34 by 24 bit signed multiplier through the cosine and sine
// interpolation, the two projection products, the two halves of the scaling by 1/dt and
// the acceleration product. A point marked run_end then adds another difference and
// acceleration product for the tail, then the closing result. The point stall stays
// high from acceptance until the last result of the point has been loaded into the
// output register; results are one deep and a finished result may wait there while
// the next point is taken.
`include "path_speed_accel_profiler_defines.svh"

module path_speed_accel_profiler (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_stall,
	input psap_pkg::point_t point,
	output logic result_valid,
	input logic result_stall,
	output psap_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [psap_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [psap_pkg::CFG_DATA_W-1:0] cfg_data
);
	import psap_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_COS = 4'd1;
	localparam logic [3:0] ST_SIN = 4'd2;
	localparam logic [3:0] ST_PX = 4'd3;
	localparam logic [3:0] ST_PY = 4'd4;
	localparam logic [3:0] ST_PSUM = 4'd5;
	localparam logic [3:0] ST_VL = 4'd6;
	localparam logic [3:0] ST_VH = 4'd7;
	localparam logic [3:0] ST_VSUM = 4'd8;
	localparam logic [3:0] ST_DIFF = 4'd9;
	localparam logic [3:0] ST_AMUL = 4'd10;
	localparam logic [3:0] ST_EMITV = 4'd11;
	localparam logic [3:0] ST_EMIT0 = 4'd12;
	localparam logic [3:0] ST_EMITZ = 4'd13;

	logic [3:0] state_q;
	logic [1:0] pts_q;
	logic [19:0] step_q;
	logic [22:0] inv_q;
	logic signed [31:0] xw0_q, xw1_q, yw0_q, yw1_q;
	logic [15:0] hp_q;
	logic signed [31:0] vpend_q;
	logic [47:0] time_q;
	logic end_q, tail_q, err_q;
	logic out_valid_q;
	result_t out_q;

	logic signed [32:0] dx_q, dy_q;
	logic [15:0] ang_q;
	logic signed [17:0] c_q, s_q;
	logic signed [57:0] prod_q;
	logic [50:0] acc_q;
	logic signed [31:0] vc_q;
	logic signed [32:0] diff_q;

	logic accept;
	logic out_free, out_load;
	result_t out_d;
	sine_sel_t cos_sel, sin_sel;
	logic signed [33:0] mul_a;
	logic signed [23:0] mul_b;
	logic mul_en;
	logic signed [57:0] prod_d;
	logic signed [57:0] vsum;
	logic signed [57:0] asum;
	logic signed [31:0] accel;
	logic [48:0] time_sum;
	logic [47:0] time_next;

	assign accept = point_valid && !point_stall;
	assign point_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = out_valid_q;
	assign result = out_q;
	assign out_free = !out_valid_q || !result_stall;

	assign cos_sel = sine_select(ang_q + 16'd16384);
	assign sin_sel = sine_select(ang_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mul_en = 1'b1;
		case (state_q)
			ST_COS: begin
				mul_a = $signed({21'd0, SINE_STEP[cos_sel.idx]});
				mul_b = $signed({14'd0, cos_sel.frac});
			end
			ST_SIN: begin
				mul_a = $signed({21'd0, SINE_STEP[sin_sel.idx]});
				mul_b = $signed({14'd0, sin_sel.frac});
			end
			ST_PX: begin
				mul_a = 34'(dx_q);
				mul_b = 24'(c_q);
			end
			ST_PY: begin
				mul_a = 34'(dy_q);
				mul_b = 24'(s_q);
			end
			ST_VL: begin
				mul_a = $signed({17'd0, acc_q[16:0]});
				mul_b = $signed({1'b0, inv_q});
			end
			ST_VH: begin
				mul_a = $signed(acc_q[50:17]);
				mul_b = $signed({1'b0, inv_q});
			end
			ST_AMUL: begin
				mul_a = 34'(diff_q);
				mul_b = $signed({1'b0, inv_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	assign vsum = prod_q + $signed({34'd0, acc_q[40:17]});
	assign asum = prod_q + 58'sd32768;
	assign accel = sat32(asum[57:16]);

	assign time_sum = {1'b0, time_q} + {29'd0, step_q};
	assign time_next = time_sum[48] ? '1 : time_sum[47:0];

	always_comb begin
		out_d.velocity = '0;
		out_d.acceleration = '0;
		out_d.elapsed_time = time_q;
		out_d.status = 1'b0;
		out_d.last_of_run = 1'b0;
		case (state_q)
			ST_EMITV: begin
				out_d.velocity = vpend_q;
				out_d.acceleration = accel;
			end
			ST_EMITZ: begin
				out_d.status = err_q;
				out_d.last_of_run = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_load = out_free &&
		(state_q == ST_EMITV || state_q == ST_EMIT0 || state_q == ST_EMITZ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pts_q <= 2'd0;
			step_q <= 20'd100000;
			inv_q <= 23'd655360;
			xw0_q <= '0;
			xw1_q <= '0;
			yw0_q <= '0;
			yw1_q <= '0;
			hp_q <= '0;
			vpend_q <= '0;
			time_q <= '0;
			end_q <= 1'b0;
			tail_q <= 1'b0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEP_TIME: step_q <= cfg_data[19:0];
					REG_INVERSE_STEP: inv_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				time_q <= (state_q == ST_EMITZ) ? '0 : time_next;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						xw0_q <= xw1_q;
						xw1_q <= point.x_position;
						yw0_q <= yw1_q;
						yw1_q <= point.y_position;
						hp_q <= point.heading;
						end_q <= point.run_end;
						tail_q <= 1'b0;
						err_q <= (pts_q == 2'd0) && point.run_end;
						pts_q <= (pts_q == 2'd0) ? 2'd1 : 2'd2;
						if (pts_q[1]) begin
							state_q <= ST_COS;
						end else if (point.run_end) begin
							state_q <= pts_q[0] ? ST_EMIT0 : ST_EMITZ;
						end
					end
				end
				ST_COS: state_q <= ST_SIN;
				ST_SIN: state_q <= ST_PX;
				ST_PX: state_q <= ST_PY;
				ST_PY: state_q <= ST_PSUM;
				ST_PSUM: state_q <= ST_VL;
				ST_VL: state_q <= ST_VH;
				ST_VH: state_q <= ST_VSUM;
				ST_VSUM: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_AMUL;
				ST_AMUL: state_q <= ST_EMITV;
				ST_EMITV: begin
					if (out_load) begin
						if (tail_q) begin
							state_q <= ST_EMITZ;
						end else begin
							vpend_q <= vc_q;
							if (end_q) begin
								tail_q <= 1'b1;
								state_q <= ST_DIFF;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_EMIT0: begin
					if (out_load) begin
						state_q <= ST_EMITZ;
					end
				end
				ST_EMITZ: begin
					if (out_load) begin
						xw0_q <= '0;
						xw1_q <= '0;
						yw0_q <= '0;
						yw1_q <= '0;
						hp_q <= '0;
						vpend_q <= '0;
						pts_q <= 2'd0;
						tail_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		if (mul_en) begin
			prod_q <= prod_d;
		end
		if (accept) begin
			dx_q <= 33'(point.x_position) - 33'(xw0_q);
			dy_q <= 33'(point.y_position) - 33'(yw0_q);
			ang_q <= hp_q;
		end
		case (state_q)
			ST_SIN: c_q <= sine_finish(cos_sel, prod_q[22:0]);
			ST_PX: s_q <= sine_finish(sin_sel, prod_q[22:0]);
			ST_PY: acc_q <= prod_q[50:0];
			ST_PSUM: acc_q <= acc_q + prod_q[50:0];
			ST_VH: acc_q <= {11'd0, prod_q[39:0]} + (51'd1 << 32);
			ST_VSUM: vc_q <= sat32(vsum[57:16]);
			ST_DIFF: diff_q <= (tail_q ? 33'sd0 : 33'(vc_q)) - 33'(vpend_q);
			default: begin
			end
		endcase
	end

	`PSAP_ASSERT_NXT(a_interior_starts_seq, accept && pts_q[1], state_q == ST_COS)
	`PSAP_ASSERT_NXT(a_last_clears_run, out_load && state_q == ST_EMITZ,
		pts_q == 2'd0 && time_q == '0 && vpend_q == '0)
	`PSAP_ASSERT_NXT(a_last_returns_idle, out_load && out_d.last_of_run, state_q == ST_IDLE)
	`PSAP_ASSERT_IMP(a_error_is_last, result_valid && result.status, result.last_of_run)

endmodule

/* test/path_speed_accel_profiler_tb.sv */
// Self-checking testbench for path_speed_accel_profiler: directed runs, then random runs of
// path points under several timing settings and idle patterns. Depends on psap_pkg and the RTL;
// expected speed, acceleration and time come from a scoreboard class kept in this file.
`timescale 1ns / 1ps

import psap_pkg::*;

class profile_scoreboard;
	localparam longint unsigned TIME_CAP = 64'h0000_FFFF_FFFF_FFFF;

	int quarter_sine_q16[17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
		50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};
	bit [19:0] step_us;
	bit [22:0] inv_q16;
	longint x_hist[2];
	longint y_hist[2];
	bit [15:0] head_last;
	longint v_held;
	int unsigned seen;
	longint unsigned t_next;
	result_t expected_results[$];
	int unsigned mismatches;
	int unsigned checked;

	function new();
		step_us = 20'd100000;
		inv_q16 = 23'd655360;
		mismatches = 0;
		checked = 0;
		clear_run();
	endfunction

	function void clear_run();
		x_hist = '{0, 0};
		y_hist = '{0, 0};
		head_last = '0;
		v_held = 0;
		seen = 0;
		t_next = 0;
	endfunction

	function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		if (index == REG_STEP_TIME) begin
			step_us = data[19:0];
		end else if (index == REG_INVERSE_STEP) begin
			inv_q16 = data;
		end
	endfunction

	function longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function int sine_q16(bit [15:0] angle);
		int r;
		int idx;
		int frac;
		int mag;
		r = angle[13:0];
		if (angle[14]) begin
			r = 16384 - r;
		end
		idx = r >> 10;
		frac = r & 1023;
		if (idx >= 16) begin
			mag = quarter_sine_q16[16];
		end else begin
			mag = quarter_sine_q16[idx] +
				(((quarter_sine_q16[idx+1] - quarter_sine_q16[idx]) * frac + 512) >> 10);
		end
		return angle[15] ? -mag : mag;
	endfunction

	function longint speed_of(longint dx, longint dy, bit [15:0] h);
		longint c;
		longint s;
		longint p;
		longint ph;
		longint pl;
		longint inv;
		longint t;
		c = sine_q16(h + 16'd16384);
		s = sine_q16(h);
		inv = inv_q16;
		p = dx * c + dy * s;
		ph = p >>> 16;
		pl = p - ph * 65536;
		t = ph * inv + 65536 + ((pl * inv) >>> 16);
		return clip32(t >>> 17);
	endfunction

	function longint accel_of(longint diff);
		longint inv;
		inv = inv_q16;
		return clip32((diff * inv + 32768) >>> 16);
	endfunction

	function void push(longint v, longint a, bit st, bit last);
		result_t e;
		e.velocity = 32'(v);
		e.acceleration = 32'(a);
		e.elapsed_time = 48'(t_next);
		e.status = st;
		e.last_of_run = last;
		expected_results = {expected_results, e};
		if (t_next > TIME_CAP - step_us) begin
			t_next = TIME_CAP;
		end else begin
			t_next += step_us;
		end
	endfunction

	function void take_point(point_t pt);
		longint x;
		longint y;
		longint vc;
		x = pt.x_position;
		y = pt.y_position;
		if (seen == 0) begin
			if (pt.run_end) begin
				t_next = 0;
				push(0, 0, 1'b1, 1'b1);
				clear_run();
			end else begin
				x_hist[1] = x;
				y_hist[1] = y;
				head_last = pt.heading;
				seen = 1;
			end
			return;
		end
		if (seen == 1) begin
			x_hist[0] = x_hist[1];
			x_hist[1] = x;
			y_hist[0] = y_hist[1];
			y_hist[1] = y;
			head_last = pt.heading;
			seen = 2;
			if (pt.run_end) begin
				push(0, 0, 1'b0, 1'b0);
				push(0, 0, 1'b0, 1'b1);
				clear_run();
			end
			return;
		end
		vc = speed_of(x - x_hist[0], y - y_hist[0], head_last);
		push(v_held, accel_of(vc - v_held), 1'b0, 1'b0);
		v_held = vc;
		x_hist[0] = x_hist[1];
		x_hist[1] = x;
		y_hist[0] = y_hist[1];
		y_hist[1] = y;
		head_last = pt.heading;
		if (pt.run_end) begin
			push(vc, accel_of(-vc), 1'b0, 1'b0);
			push(0, 0, 1'b0, 1'b1);
			clear_run();
		end
	endfunction

	function void check_result(result_t r);
		result_t e;
		longint exp_f[5];
		longint act_f[5];
		string names[5] = '{"velocity", "acceleration", "elapsed_time", "status", "last_of_run"};
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result %h", $time, r);
			mismatches++;
			return;
		end
		e = expected_results.pop_front();
		checked++;
		exp_f = '{longint'(e.velocity), longint'(e.acceleration), longint'(e.elapsed_time),
			longint'(e.status), longint'(e.last_of_run)};
		act_f = '{longint'(r.velocity), longint'(r.acceleration), longint'(r.elapsed_time),
			longint'(r.status), longint'(r.last_of_run)};
		for (int i = 0; i < 5; i++) begin
			if (exp_f[i] != act_f[i]) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, names[i],
					exp_f[i], act_f[i]);
				mismatches++;
			end
		end
	endfunction

	function int unsigned pending();
		return expected_results.size();
	endfunction
endclass

module path_speed_accel_profiler_tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	point_t point = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int unsigned points_sent = 0;
	int unsigned runs_sent = 0;
	int unsigned timing_settings = 0;
	profile_scoreboard sb = new();

	path_speed_accel_profiler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result);
		end
	end

	function automatic point_t make_point(logic signed [31:0] x, logic signed [31:0] y,
			logic [15:0] h, logic e);
		point_t p;
		p.x_position = x;
		p.y_position = y;
		p.heading = h;
		p.run_end = e;
		return p;
	endfunction

	task automatic send_point(input point_t p);
		if ($urandom_range(99) < sender_idle_pct) begin
			point_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		point_valid <= 1'b1;
		point <= p;
		do @(posedge clk); while (point_stall);
		sb.take_point(p);
		points_sent++;
		if (p.run_end) begin
			runs_sent++;
		end
	endtask

	task automatic send_run(input int n, input bit smooth);
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0] h;
		int span;
		x = $signed($urandom_range(2_000_000)) - 1_000_000;
		y = $signed($urandom_range(2_000_000)) - 1_000_000;
		h = 16'($urandom);
		span = 1 << $urandom_range(24);
		for (int i = 0; i < n; i++) begin
			if (!smooth || $urandom_range(19) == 0) begin
				send_point(make_point($urandom, $urandom, 16'($urandom), i == n - 1));
			end else begin
				x += $signed($urandom_range(2 * span)) - span;
				y += $signed($urandom_range(2 * span)) - span;
				h += 16'($signed($urandom_range(2000)) - 1000);
				send_point(make_point(x, y, h, i == n - 1));
			end
		end
	endtask

	// Let every outstanding request finish before the next register write.
	task automatic drain();
		point_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic program_timing(input logic [CFG_DATA_W-1:0] step_val,
			input logic [CFG_DATA_W-1:0] inv_val);
		cfg_valid <= 1'b1;
		cfg_index <= REG_STEP_TIME;
		cfg_data <= step_val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(REG_STEP_TIME, step_val);
		cfg_index <= REG_INVERSE_STEP;
		cfg_data <= inv_val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(REG_INVERSE_STEP, inv_val);
		cfg_valid <= 1'b0;
		timing_settings++;
	endtask

	initial begin
		int unsigned phase_start;
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(make_point(5, -7, 16'd100, 1'b1));
		send_point(make_point(0, 0, 16'd0, 1'b0));
		send_point(make_point(1000, 2000, 16'd16384, 1'b1));
		send_point(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 16'd0, 1'b0));
		send_point(make_point(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd16384, 1'b0));
		send_point(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd32768, 1'b0));
		send_point(make_point(32'sh8000_0000, 32'sh8000_0000, 16'd49152, 1'b0));
		send_point(make_point(0, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0));
		send_point(make_point(-1, 1, 16'd8191, 1'b1));
		for (int i = 0; i < 4; i++) begin
			send_point(make_point(1000 * i, 1000 * i, 16'd8192, i == 3));
		end
		drain();
		program_timing(23'd100000, 23'd0);
		send_run(3, 1'b1);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					program_timing(23'd10001, 23'd6553600);
				end
				1: begin
					program_timing(23'd1000000, 23'd65536);
				end
				2: begin
					program_timing(23'h7FFFFF, 23'h7FFFFF);
				end
				default: begin
					program_timing(23'($urandom_range(1000000, 10001)),
						23'($urandom_range(6553600, 65536)));
				end
			endcase
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 71;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 71;
				end
				default: begin
					sender_idle_pct = 17;
					receiver_stall_pct = 17;
				end
			endcase
			phase_start = points_sent;
			while (points_sent - phase_start < 89) begin
				case ($urandom_range(9))
					0: n = 1;
					1: n = 2;
					default: n = $urandom_range(14, 3);
				endcase
				send_run(n, $urandom_range(3) != 0);
			end
			drain();
			sender_idle_pct = 0;
			receiver_stall_pct = 0;
		end

		$display("Summary: %0d points in %0d runs, %0d results checked, %0d timing settings.",
			points_sent, runs_sent, sb.checked, timing_settings);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("path_speed_accel_profiler_tb OK");
		end else begin
			$display("path_speed_accel_profiler_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d results still expected.", sb.pending());
		$display("path_speed_accel_profiler_tb NOT OK");
		$finish;
	end
endmodule
